// ===== sv/damped_spring_force_3d_assert.svh =====
// ----------------------------------------------------------------------------
// damped spring force assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef DAMPED_SPRING_FORCE_3D_ASSERT_SVH
`define DAMPED_SPRING_FORCE_3D_ASSERT_SVH

// checked only out of reset
`define DSF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define DSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg
// shared constants and register codes of the damped spring force block
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int unsigned DSF_FRAC_BITS       = 16;
  localparam int unsigned DSF_WORD_BITS       = 32;
  localparam int unsigned DSF_STEPS_PER_STAGE = 4;

  // configuration port
  localparam int unsigned DSF_CFG_W      = 31;
  localparam int unsigned DSF_CFG_DATA_W = 32;
  localparam int unsigned DSF_CFG_IDX_W  = 2;

  typedef enum logic [DSF_CFG_IDX_W-1:0] {
    DSF_CFG_STIFFNESS,
    DSF_CFG_DAMPING,
    DSF_CFG_NATURAL_LENGTH
  } dsf_cfg_e;

endpackage

// ===== sv/dsf_sqrt.sv =====
// ----------------------------------------------------------------------------
// dsf_sqrt
// pipelined integer square root, a few result bits per stage
// ----------------------------------------------------------------------------
module dsf_sqrt import dsf_pkg::*; #(
  parameter int unsigned XW  = 68,
  parameter int unsigned PW  = 1,
  parameter int unsigned SPS = DSF_STEPS_PER_STAGE
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [XW-1:0]   in_x_i,
  input  logic [PW-1:0]   in_pay_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [XW/2-1:0] out_root_o,
  output logic [PW-1:0]   out_pay_o
);

  localparam int unsigned RW   = XW / 2;
  localparam int unsigned NS   = (RW + SPS - 1) / SPS;
  localparam int unsigned REMW = RW + 1;

  logic [REMW-1:0] rem_q  [NS];
  logic [XW-1:0]   x_q    [NS];
  logic [RW-1:0]   root_q [NS];
  logic [PW-1:0]   pay_q  [NS];
  logic [NS-1:0]   v_q;
  logic [NS:0]     en;

  assign en[NS] = out_ready_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [REMW-1:0] rem_s, rem_d;
    logic [XW-1:0]   x_s, x_d;
    logic [RW-1:0]   root_s, root_d;
    logic [PW-1:0]   pay_s;
    logic            v_s;

    if (k == 0) begin : g_first
      assign rem_s  = '0;
      assign x_s    = in_x_i;
      assign root_s = '0;
      assign pay_s  = in_pay_i;
      assign v_s    = in_valid_i;
    end else begin : g_next
      assign rem_s  = rem_q[k-1];
      assign x_s    = x_q[k-1];
      assign root_s = root_q[k-1];
      assign pay_s  = pay_q[k-1];
      assign v_s    = v_q[k-1];
    end

    assign en[k] = ~v_q[k] | en[k+1];

    always_comb begin
      logic [REMW+1:0] r2;
      logic [REMW+1:0] t;
      rem_d  = rem_s;
      x_d    = x_s;
      root_d = root_s;
      r2     = '0;
      t      = '0;
      for (int j = 0; j < SPS; j++) begin
        if (k * SPS + j < RW) begin
          r2 = {rem_d, x_d[XW-1:XW-2]};
          t  = {1'b0, root_d, 2'b01};
          x_d = {x_d[XW-3:0], 2'b00};
          if (r2 >= t) begin
            r2     = r2 - t;
            root_d = {root_d[RW-2:0], 1'b1};
          end else begin
            root_d = {root_d[RW-2:0], 1'b0};
          end
          rem_d = r2[REMW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d;
        x_q[k]    <= x_d;
        root_q[k] <= root_d;
        pay_q[k]  <= pay_s;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_root_o  = root_q[NS-1];
  assign out_pay_o   = pay_q[NS-1];

endmodule

// ===== sv/dsf_div.sv =====
// ----------------------------------------------------------------------------
// dsf_div
// pipelined restoring divider, lanes share one divisor
// ----------------------------------------------------------------------------
module dsf_div import dsf_pkg::*; #(
  parameter int unsigned NL   = 1,
  parameter int unsigned DENW = 34,
  parameter int unsigned QB   = 35,
  parameter int unsigned PW   = 1,
  parameter int unsigned SPS  = DSF_STEPS_PER_STAGE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [NL-1:0][DENW+QB-1:0]     in_num_i,
  input  logic [DENW-1:0]                in_den_i,
  input  logic [PW-1:0]                  in_pay_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [NL-1:0][QB-1:0]          out_quo_o,
  output logic [PW-1:0]                  out_pay_o
);

  // numerator top part must be below the divisor
  localparam int unsigned NW = DENW + QB;
  localparam int unsigned NS = (QB + SPS - 1) / SPS;

  logic [NL-1:0][NW-1:0] wk_q  [NS];
  logic [DENW-1:0]       den_q [NS];
  logic [PW-1:0]         pay_q [NS];
  logic [NS-1:0]         v_q;
  logic [NS:0]           en;

  assign en[NS] = out_ready_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [NL-1:0][NW-1:0] wk_s, wk_d;
    logic [DENW-1:0]       den_s;
    logic [PW-1:0]         pay_s;
    logic                  v_s;

    if (k == 0) begin : g_first
      assign wk_s  = in_num_i;
      assign den_s = in_den_i;
      assign pay_s = in_pay_i;
      assign v_s   = in_valid_i;
    end else begin : g_next
      assign wk_s  = wk_q[k-1];
      assign den_s = den_q[k-1];
      assign pay_s = pay_q[k-1];
      assign v_s   = v_q[k-1];
    end

    assign en[k] = ~v_q[k] | en[k+1];

    always_comb begin
      logic [DENW:0] r2;
      logic          qbit;
      wk_d = wk_s;
      r2   = '0;
      qbit = 1'b0;
      for (int l = 0; l < NL; l++) begin
        for (int j = 0; j < SPS; j++) begin
          if (k * SPS + j < QB) begin
            r2   = {wk_d[l][NW-1:QB], wk_d[l][QB-1]};
            qbit = (r2 >= {1'b0, den_s});
            if (qbit) begin
              r2 = r2 - {1'b0, den_s};
            end
            wk_d[l] = {r2[DENW-1:0], wk_d[l][QB-2:0], qbit};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        wk_q[k]  <= wk_d;
        den_q[k] <= den_s;
        pay_q[k] <= pay_s;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      out_quo_o[l] = wk_q[NS-1][l][QB-1:0];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign out_pay_o   = pay_q[NS-1];

endmodule

// ===== sv/damped_spring_force_3d.sv =====
// ----------------------------------------------------------------------------
// damped_spring_force_3d
// force on mass A of a damped Hooke spring between two 3D masses
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_ready_o    pos_a/b, vel_a/b xyz
//  out       output     out_valid_o / out_ready_i  force xyz, zero_length
//  cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  one item per cycle while out_ready_i is high, every stage registered with
//  its own valid; the square root pipe and the two restoring divider pipes
//  each retire S root or quotient bits per stage
//  reset clears valids and loads the register defaults, no clearing pass
//  a stall holds only the full stages in front of it, bubbles close up
//  cfg writes are taken every cycle
// ----------------------------------------------------------------------------
module damped_spring_force_3d import dsf_pkg::*; #(
  parameter int unsigned FRAC_BITS       = DSF_FRAC_BITS,
  parameter int unsigned WORD_BITS       = DSF_WORD_BITS,
  parameter int unsigned STEPS_PER_STAGE = DSF_STEPS_PER_STAGE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [DSF_CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [DSF_CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] pos_a_x_i,
  input  logic signed [WORD_BITS-1:0] pos_a_y_i,
  input  logic signed [WORD_BITS-1:0] pos_a_z_i,
  input  logic signed [WORD_BITS-1:0] pos_b_x_i,
  input  logic signed [WORD_BITS-1:0] pos_b_y_i,
  input  logic signed [WORD_BITS-1:0] pos_b_z_i,
  input  logic signed [WORD_BITS-1:0] vel_a_x_i,
  input  logic signed [WORD_BITS-1:0] vel_a_y_i,
  input  logic signed [WORD_BITS-1:0] vel_a_z_i,
  input  logic signed [WORD_BITS-1:0] vel_b_x_i,
  input  logic signed [WORD_BITS-1:0] vel_b_y_i,
  input  logic signed [WORD_BITS-1:0] vel_b_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] force_x_o,
  output logic signed [WORD_BITS-1:0] force_y_o,
  output logic signed [WORD_BITS-1:0] force_z_o,
  output logic                        zero_length_o
);

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned CW   = DSF_CFG_W;
  localparam int unsigned DW   = W + 1;            // position / velocity difference
  localparam int unsigned SQW  = 2 * DW + 2;       // sum of squares
  localparam int unsigned LW   = SQW / 2;          // length
  localparam int unsigned DOTW = 2 * DW + 2;       // dot product
  localparam int unsigned QB   = DW + 2;           // magnitude bits of dot/len
  localparam int unsigned QW   = QB + 1;
  localparam int unsigned HDW  = ((LW > CW) ? LW : CW) + 1;
  localparam int unsigned HPW  = CW + 1 + HDW;     // stiffness product
  localparam int unsigned HW   = HPW - F;
  localparam int unsigned DPW  = CW + 1 + QW;      // damping product
  localparam int unsigned DMW  = DPW - F;
  localparam int unsigned SW   = ((HW > DMW) ? HW : DMW) + 1;
  localparam int unsigned SL   = (SW + 1) / 2;     // low half of the split multiply
  localparam int unsigned SH   = SW - SL;
  localparam int unsigned NUMW = DW + SW;
  localparam int unsigned FNW  = LW + W;           // force divider numerator

  typedef struct packed {
    logic [2:0][DW-1:0] dp;
    logic [DOTW-1:0]    dot;
  } sq_pay_t;

  typedef struct packed {
    logic [2:0][DW-1:0] dp;
    logic [HPW-1:0]     hprod;
    logic [LW-1:0]      len;
    logic               dot_neg;
    logic               zero;
  } dq_pay_t;

  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] ovf;
    logic       zero;
  } df_pay_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0] stiff_q, damp_q, nat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q <= CW'(1) << F;
      damp_q  <= '0;
      nat_q   <= CW'(1) << F;
    end else if (cfg_valid_i) begin
      unique case (dsf_cfg_e'(cfg_index_i))
        DSF_CFG_STIFFNESS:      stiff_q <= cfg_data_i[CW-1:0];
        DSF_CFG_DAMPING:        damp_q  <= cfg_data_i[CW-1:0];
        DSF_CFG_NATURAL_LENGTH: nat_q   <= cfg_data_i[CW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage valids and the ready chain
  // stages 1-3 before the root, 4 before dot/len, 5-10 before the force
  // divide, 11 is the output register
  // --------------------------------------------------------------------------
  logic [11:1] v_q, v_d, rdy;
  logic        sq_in_ready, sq_out_valid;
  logic        dq_in_ready, dq_out_valid;
  logic        df_in_ready, df_out_valid;

  always_comb begin
    rdy[11] = ~v_q[11] | out_ready_i;
    rdy[10] = ~v_q[10] | df_in_ready;
    for (int k = 9; k >= 5; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
    rdy[4] = ~v_q[4] | dq_in_ready;
    rdy[3] = ~v_q[3] | sq_in_ready;
    rdy[2] = ~v_q[2] | rdy[3];
    rdy[1] = ~v_q[1] | rdy[2];

    v_d[1]  = in_valid_i;
    v_d[2]  = v_q[1];
    v_d[3]  = v_q[2];
    v_d[4]  = sq_out_valid;
    v_d[5]  = dq_out_valid;
    for (int k = 6; k <= 10; k++) begin
      v_d[k] = v_q[k-1];
    end
    v_d[11] = df_out_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= 11; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = v_q[11];

  // --------------------------------------------------------------------------
  // stage 1: separation and relative velocity
  // --------------------------------------------------------------------------
  logic [2:0][W-1:0]  pa, pb, va, vb;
  logic [2:0][DW-1:0] dp1_q, dp1_d, dv1_q, dv1_d;

  assign pa = {pos_a_z_i, pos_a_y_i, pos_a_x_i};
  assign pb = {pos_b_z_i, pos_b_y_i, pos_b_x_i};
  assign va = {vel_a_z_i, vel_a_y_i, vel_a_x_i};
  assign vb = {vel_b_z_i, vel_b_y_i, vel_b_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp1_d[i] = {pa[i][W-1], pa[i]} - {pb[i][W-1], pb[i]};
      dv1_d[i] = {va[i][W-1], va[i]} - {vb[i][W-1], vb[i]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      dp1_q <= dp1_d;
      dv1_q <= dv1_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: squares and dot terms, one multiplier each
  // --------------------------------------------------------------------------
  logic [2:0][2*DW-1:0] sq2_q, sq2_d, pr2_q, pr2_d;
  logic [2:0][DW-1:0]   dp2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq2_d[i] = $signed(dp1_q[i]) * $signed(dp1_q[i]);
      pr2_d[i] = $signed(dv1_q[i]) * $signed(dp1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sq2_q <= sq2_d;
      pr2_q <= pr2_d;
      dp2_q <= dp1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sums
  // --------------------------------------------------------------------------
  logic [SQW-1:0]  sumsq3_q, sumsq3_d;
  logic [DOTW-1:0] dot3_q, dot3_d;
  logic [2:0][DW-1:0] dp3_q;

  assign sumsq3_d = SQW'(sq2_q[0]) + SQW'(sq2_q[1]) + SQW'(sq2_q[2]);
  assign dot3_d   = DOTW'($signed(pr2_q[0])) + DOTW'($signed(pr2_q[1]))
                  + DOTW'($signed(pr2_q[2]));

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      sumsq3_q <= sumsq3_d;
      dot3_q   <= dot3_d;
      dp3_q    <= dp2_q;
    end
  end

  // --------------------------------------------------------------------------
  // length = floor(sqrt(sum of squares))
  // --------------------------------------------------------------------------
  sq_pay_t        sq_pay_in, sq_pay_out;
  logic [LW-1:0]  sq_root;

  assign sq_pay_in.dp  = dp3_q;
  assign sq_pay_in.dot = dot3_q;

  dsf_sqrt #(
    .XW (SQW),
    .PW ($bits(sq_pay_t)),
    .SPS(STEPS_PER_STAGE)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v_q[3]),
    .in_ready_o (sq_in_ready),
    .in_x_i     (sumsq3_q),
    .in_pay_i   (sq_pay_in),
    .out_valid_o(sq_out_valid),
    .out_ready_i(rdy[4]),
    .out_root_o (sq_root),
    .out_pay_o  (sq_pay_out)
  );

  // --------------------------------------------------------------------------
  // stage 4: stiffness product and dot magnitude
  // --------------------------------------------------------------------------
  logic signed [HDW-1:0] hdiff;
  logic [DOTW-1:0]       dmag;
  logic                  dneg;
  dq_pay_t               dq4_q, dq4_d;
  logic [LW+QB-1:0]      dnum4_q, dnum4_d;

  always_comb begin
    hdiff = $signed({{(HDW-LW){1'b0}}, sq_root}) - $signed({{(HDW-CW){1'b0}}, nat_q});
    dneg  = sq_pay_out.dot[DOTW-1];
    dmag  = dneg ? (~sq_pay_out.dot + 1'b1) : sq_pay_out.dot;
    dq4_d.dp      = sq_pay_out.dp;
    dq4_d.hprod   = $signed({1'b0, stiff_q}) * hdiff;
    dq4_d.len     = sq_root;
    dq4_d.dot_neg = dneg;
    dq4_d.zero    = (sq_root == '0);
    dnum4_d       = {{(LW+QB-DOTW){1'b0}}, dmag};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      dq4_q   <= dq4_d;
      dnum4_q <= dnum4_d;
    end
  end

  // --------------------------------------------------------------------------
  // |dot| / len
  // --------------------------------------------------------------------------
  dq_pay_t              dq_pay_out;
  logic [0:0][QB-1:0]   dq_quo;

  dsf_div #(
    .NL  (1),
    .DENW(LW),
    .QB  (QB),
    .PW  ($bits(dq_pay_t)),
    .SPS (STEPS_PER_STAGE)
  ) u_div_dot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v_q[4]),
    .in_ready_o (dq_in_ready),
    .in_num_i   (dnum4_q),
    .in_den_i   (dq4_q.len),
    .in_pay_i   (dq4_q),
    .out_valid_o(dq_out_valid),
    .out_ready_i(rdy[5]),
    .out_quo_o  (dq_quo),
    .out_pay_o  (dq_pay_out)
  );

  // --------------------------------------------------------------------------
  // stage 5: damping product, hooke term truncated toward zero
  // --------------------------------------------------------------------------
  logic [QW-1:0]      qs, qv;
  logic [HPW-1:0]     hb;
  logic [DPW-1:0]     dprod5_q, dprod5_d;
  logic [HW-1:0]      hooke5_q, hooke5_d;
  logic [2:0][DW-1:0] dp5_q;
  logic [LW-1:0]      len5_q;
  logic               zero5_q;

  always_comb begin
    qs       = {1'b0, dq_quo[0]};
    qv       = dq_pay_out.dot_neg ? (~qs + 1'b1) : qs;
    dprod5_d = $signed({1'b0, damp_q}) * $signed(qv);
    hb       = dq_pay_out.hprod + {{(HPW-F){1'b0}}, {F{dq_pay_out.hprod[HPW-1]}}};
    hooke5_d = hb[HPW-1:F];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      dprod5_q <= dprod5_d;
      hooke5_q <= hooke5_d;
      dp5_q    <= dq_pay_out.dp;
      len5_q   <= dq_pay_out.len;
      zero5_q  <= dq_pay_out.zero;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: damping term and total scalar s = hooke + damping
  // --------------------------------------------------------------------------
  logic [DPW-1:0]     db;
  logic [DMW-1:0]     dterm;
  logic [SW-1:0]      s6_q, s6_d;
  logic [2:0][DW-1:0] dp6_q;
  logic [LW-1:0]      len6_q;
  logic               zero6_q;

  always_comb begin
    db    = dprod5_q + {{(DPW-F){1'b0}}, {F{dprod5_q[DPW-1]}}};
    dterm = db[DPW-1:F];
    s6_d  = {{(SW-HW){hooke5_q[HW-1]}}, hooke5_q} + {{(SW-DMW){dterm[DMW-1]}}, dterm};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s6_q    <= s6_d;
      dp6_q   <= dp5_q;
      len6_q  <= len5_q;
      zero6_q <= zero5_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: sign and magnitude, force on A is -dp*s/len
  // --------------------------------------------------------------------------
  logic [SW-1:0]      smag7_q, smag7_d;
  logic [2:0][DW-1:0] dpm7_q, dpm7_d;
  logic [2:0]         neg7_q, neg7_d;
  logic [LW-1:0]      len7_q;
  logic               zero7_q;

  always_comb begin
    smag7_d = s6_q[SW-1] ? (~s6_q + 1'b1) : s6_q;
    for (int i = 0; i < 3; i++) begin
      dpm7_d[i] = dp6_q[i][DW-1] ? (~dp6_q[i] + 1'b1) : dp6_q[i];
      neg7_d[i] = ~(dp6_q[i][DW-1] ^ s6_q[SW-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      smag7_q <= smag7_d;
      dpm7_q  <= dpm7_d;
      neg7_q  <= neg7_d;
      len7_q  <= len6_q;
      zero7_q <= zero6_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: |dp| * |s| as two partial products per axis
  // --------------------------------------------------------------------------
  logic [2:0][DW+SL-1:0] plo8_q, plo8_d;
  logic [2:0][DW+SH-1:0] phi8_q, phi8_d;
  logic [2:0]            neg8_q;
  logic [LW-1:0]         len8_q;
  logic                  zero8_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      plo8_d[i] = dpm7_q[i] * smag7_q[SL-1:0];
      phi8_d[i] = dpm7_q[i] * smag7_q[SW-1:SL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      plo8_q  <= plo8_d;
      phi8_q  <= phi8_d;
      neg8_q  <= neg7_q;
      len8_q  <= len7_q;
      zero8_q <= zero7_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: partial product sum
  // --------------------------------------------------------------------------
  logic [2:0][NUMW-1:0] num9_q, num9_d;
  logic [2:0]           neg9_q;
  logic [LW-1:0]        len9_q;
  logic                 zero9_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num9_d[i] = NUMW'(plo8_q[i]) + (NUMW'(phi8_q[i]) << SL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[9]) begin
      num9_q  <= num9_d;
      neg9_q  <= neg8_q;
      len9_q  <= len8_q;
      zero9_q <= zero8_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: overflow check, a quotient of 2^W or more saturates anyway
  // --------------------------------------------------------------------------
  logic [NUMW-1:0]      lim;
  logic [2:0][FNW-1:0]  fnum10_q, fnum10_d;
  df_pay_t              df10_q, df10_d;
  logic [LW-1:0]        len10_q;

  always_comb begin
    lim = NUMW'({len9_q, {W{1'b0}}});
    df10_d.neg  = neg9_q;
    df10_d.zero = zero9_q;
    for (int i = 0; i < 3; i++) begin
      df10_d.ovf[i] = (num9_q[i] >= lim);
      fnum10_d[i]   = df10_d.ovf[i] ? '0 : num9_q[i][FNW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[10]) begin
      fnum10_q <= fnum10_d;
      df10_q   <= df10_d;
      len10_q  <= len9_q;
    end
  end

  // --------------------------------------------------------------------------
  // |dp_i * s| / len, three lanes
  // --------------------------------------------------------------------------
  df_pay_t           df_pay_out;
  logic [2:0][W-1:0] df_quo;

  dsf_div #(
    .NL  (3),
    .DENW(LW),
    .QB  (W),
    .PW  ($bits(df_pay_t)),
    .SPS (STEPS_PER_STAGE)
  ) u_div_force (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v_q[10]),
    .in_ready_o (df_in_ready),
    .in_num_i   (fnum10_q),
    .in_den_i   (len10_q),
    .in_pay_i   (df10_q),
    .out_valid_o(df_out_valid),
    .out_ready_i(rdy[11]),
    .out_quo_o  (df_quo),
    .out_pay_o  (df_pay_out)
  );

  // --------------------------------------------------------------------------
  // stage 11: sign, saturation, zero length, output register
  // --------------------------------------------------------------------------
  logic [2:0][W-1:0] force_q, force_d;
  logic              zero_q;
  logic [W-1:0]      max_pos, min_neg;

  assign max_pos = {1'b0, {(W-1){1'b1}}};
  assign min_neg = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (df_pay_out.zero) begin
        force_d[i] = '0;
      end else if (df_pay_out.ovf[i] || df_quo[i][W-1]) begin
        force_d[i] = df_pay_out.neg[i] ? min_neg : max_pos;
      end else begin
        force_d[i] = df_pay_out.neg[i] ? (~df_quo[i] + 1'b1) : df_quo[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[11]) begin
      force_q <= force_d;
      zero_q  <= df_pay_out.zero;
    end
  end

  assign force_x_o     = force_q[0];
  assign force_y_o     = force_q[1];
  assign force_z_o     = force_q[2];
  assign zero_length_o = zero_q;

endmodule

// ===== sv/dsf_checker.sv =====
// ----------------------------------------------------------------------------
// dsf_checker
// port level checks of the damped spring force block
// ----------------------------------------------------------------------------
`include "damped_spring_force_3d_assert.svh"

module dsf_checker import dsf_pkg::*; #(
  parameter int unsigned WORD_BITS = DSF_WORD_BITS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [WORD_BITS-1:0] force_x_o,
  input logic signed [WORD_BITS-1:0] force_y_o,
  input logic signed [WORD_BITS-1:0] force_z_o,
  input logic                        zero_length_o
);

  // a waiting result holds
  `DSF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(force_x_o) && $stable(force_y_o) && $stable(force_z_o) && $stable(zero_length_o), "result changed while stalled")

  // coincident endpoints give no force
  `DSF_ASSERT(a_zero_force, clk_i, rst_ni, out_valid_o && zero_length_o |-> force_x_o == '0 && force_y_o == '0 && force_z_o == '0, "nonzero force at zero length")

  // an empty output stage lets the whole pipe move
  `DSF_ASSERT(a_ready_chain, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with output empty")

  // nothing shows during reset
  `DSF_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

bind damped_spring_force_3d dsf_checker #(.WORD_BITS(WORD_BITS)) u_dsf_checker (.*);

// ===== tb/tb_damped_spring_force_3d.sv =====
// ----------------------------------------------------------------------------
// tb_damped_spring_force_3d
// self-checking bench: streams spring items through the block under random
// source and sink stalls, predicts every force result in wide exact integer
// arithmetic and compares the results in order, over several register sets
// ----------------------------------------------------------------------------
module tb_damped_spring_force_3d import dsf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W           = DSF_WORD_BITS;
  localparam int unsigned FB          = DSF_FRAC_BITS;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 48;   // above the pipe depth
  localparam logic [DSF_CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;  // no register here
  localparam logic signed [W-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] S_MIN = 32'sh80000000;

  typedef struct {
    logic signed [W-1:0] pa [3];
    logic signed [W-1:0] pb [3];
    logic signed [W-1:0] va [3];
    logic signed [W-1:0] vb [3];
  } spring_t;

  typedef struct {
    logic signed [W-1:0] f [3];
    logic                zl;
  } force_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [DSF_CFG_IDX_W-1:0]  cfg_index;
  logic [DSF_CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [W-1:0] pa_x, pa_y, pa_z, pb_x, pb_y, pb_z;
  logic signed [W-1:0] va_x, va_y, va_z, vb_x, vb_y, vb_z;
  logic signed [W-1:0] fx, fy, fz;
  logic zl;

  damped_spring_force_3d dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pos_a_x_i(pa_x), .pos_a_y_i(pa_y), .pos_a_z_i(pa_z),
    .pos_b_x_i(pb_x), .pos_b_y_i(pb_y), .pos_b_z_i(pb_z),
    .vel_a_x_i(va_x), .vel_a_y_i(va_y), .vel_a_z_i(va_z),
    .vel_b_x_i(vb_x), .vel_b_y_i(vb_y), .vel_b_z_i(vb_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .force_x_o(fx), .force_y_o(fy), .force_z_o(fz),
    .zero_length_o(zl)
  );

  // local copy of the spring registers
  logic [DSF_CFG_W-1:0] k_spring, c_damp, rest_len;

  spring_t springs_to_send [$];
  force_t  forces_due [$];
  int      n_mismatch;
  int      n_accepted, n_queued;
  bit      idle_en;
  bit      in_took;
  int      in_gap, out_gap;
  int      cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // exact floor square root, operand below 2^80
  function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
    logic [127:0] r, t;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // force on mass A for one spring, exact wide arithmetic then clamp
  function automatic force_t spring_force(input spring_t s);
    force_t r;
    logic signed [127:0] dp [3];
    logic signed [127:0] dv [3];
    logic signed [127:0] sumsq, dotp, len, hooke, q, damp, tot, fi;
    sumsq = '0;
    dotp  = '0;
    for (int i = 0; i < 3; i++) begin
      dp[i] = s.pa[i] - s.pb[i];
      dv[i] = s.va[i] - s.vb[i];
      sumsq += dp[i] * dp[i];
      dotp  += dv[i] * dp[i];
    end
    len = $signed(floor_sqrt(sumsq));
    if (len == 0) begin
      // coincident endpoints: no direction, force held at zero
      foreach (r.f[i]) r.f[i] = '0;
      r.zl = 1'b1;
      return r;
    end
    // divisions truncate toward zero, as the shifts in the block do
    hooke = ($signed({97'd0, k_spring}) * (len - $signed({97'd0, rest_len})))
            / $signed(128'd1 << FB);
    q     = dotp / len;
    damp  = ($signed({97'd0, c_damp}) * q) / $signed(128'd1 << FB);
    tot   = hooke + damp;
    for (int i = 0; i < 3; i++) begin
      fi = -(dp[i] * tot) / len;
      if (fi > $signed({{96{1'b0}}, S_MAX}))      r.f[i] = S_MAX;
      else if (fi < $signed({{96{1'b1}}, S_MIN})) r.f[i] = S_MIN;
      else                                        r.f[i] = fi[W-1:0];
    end
    r.zl = 1'b0;
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_damped_spring_force_3d: FAIL");
      $finish;
    end
  end

  // input side: note each accepted item and queue its predicted force
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      spring_t s;
      s.pa = '{pa_x, pa_y, pa_z};
      s.pb = '{pb_x, pb_y, pb_z};
      s.va = '{va_x, va_y, va_z};
      s.vb = '{vb_x, vb_y, vb_z};
      forces_due.insert(forces_due.size(), spring_force(s));
      n_accepted <= n_accepted + 1;
    end
  end

  // output side: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (forces_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result f=%0d %0d %0d zl=%0b", fx, fy, fz, zl);
      end else begin
        force_t e;
        e = forces_due.pop_front();
        if (e.f[0] !== fx || e.f[1] !== fy || e.f[2] !== fz || e.zl !== zl) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch exp f=%0d %0d %0d zl=%0b got f=%0d %0d %0d zl=%0b",
                     e.f[0], e.f[1], e.f[2], e.zl, fx, fy, fz, zl);
        end
      end
    end
  end

  // item driver, changes on the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (springs_to_send.size() > 0) begin
        spring_t s;
        s = springs_to_send.pop_front();
        {pa_x, pa_y, pa_z} <= {s.pa[0], s.pa[1], s.pa[2]};
        {pb_x, pb_y, pb_z} <= {s.pb[0], s.pb[1], s.pb[2]};
        {va_x, va_y, va_z} <= {s.va[0], s.va[1], s.va[2]};
        {vb_x, vb_y, vb_z} <= {s.vb[0], s.vb[1], s.vb[2]};
        in_valid <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink stalls in bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 13);
      end
    end
  end

  // register write, only called with the pipe empty
  task automatic write_reg(input logic [DSF_CFG_IDX_W-1:0] idx,
                           input logic [DSF_CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      DSF_CFG_STIFFNESS:      k_spring = val[DSF_CFG_W-1:0];
      DSF_CFG_DAMPING:        c_damp   = val[DSF_CFG_W-1:0];
      DSF_CFG_NATURAL_LENGTH: rest_len = val[DSF_CFG_W-1:0];
      default: ;              // spare index, the block drops it
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] k, input logic [31:0] c, input logic [31:0] l);
    write_reg(DSF_CFG_STIFFNESS, k);
    write_reg(DSF_CFG_DAMPING, c);
    write_reg(DSF_CFG_NATURAL_LENGTH, l);
  endtask

  // wait until every queued item is in and every force is out
  task automatic drain();
    wait (springs_to_send.size() == 0);
    wait (n_accepted == n_queued);
    wait (forces_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] rand_coord(input int mode);
    case (mode)
      0:       return $urandom();                                     // full range
      1:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  task automatic queue_spring(input spring_t s);
    springs_to_send.insert(springs_to_send.size(), s);
    n_queued++;
  endtask

  task automatic queue_directed();
    spring_t s;
    logic signed [W-1:0] ext [4];
    ext = '{S_MAX, S_MIN, 32'sd0, 32'sd65536};
    // coincident endpoints, with and without motion
    s.pa = '{32'sd5, -32'sd7, 32'sd9}; s.pb = s.pa;
    s.va = '{S_MAX, S_MIN, 32'sd1};    s.vb = '{S_MIN, S_MAX, -32'sd1};
    queue_spring(s);
    s.va = '{0, 0, 0}; s.vb = '{0, 0, 0};
    queue_spring(s);
    // unit separation along each axis
    for (int i = 0; i < 3; i++) begin
      s.pa = '{0, 0, 0}; s.pb = '{0, 0, 0}; s.pa[i] = 32'sd65536;
      s.va = '{32'sd65536, -32'sd65536, 32'sd131072}; s.vb = '{0, 0, 0};
      queue_spring(s);
    end
    // smallest nonzero separation
    s.pa = '{32'sd1, 0, 0}; s.pb = '{0, 0, 0};
    queue_spring(s);
    // field extremes in all combinations of A/B
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++) begin
        s.pa = '{ext[a], ext[b], ext[a]}; s.pb = '{ext[b], ext[a], ext[3-b]};
        s.va = '{ext[a], ext[3-a], ext[b]}; s.vb = '{ext[b], ext[a], ext[3-a]};
        queue_spring(s);
      end
  endtask

  task automatic queue_random(input int n);
    spring_t s;
    int mode;
    for (int j = 0; j < n; j++) begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        s.pa[i] = rand_coord(mode);
        s.pb[i] = rand_coord(mode);
        s.va[i] = rand_coord($urandom_range(0, 2));
        s.vb[i] = rand_coord($urandom_range(0, 2));
      end
      if ($urandom_range(0, 19) == 0) s.pb = s.pa;   // occasional zero length
      queue_spring(s);
    end
  endtask

  // stimulus and end of run
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; out_ready = 1'b0;
    {pa_x, pa_y, pa_z, pb_x, pb_y, pb_z} = '0;
    {va_x, va_y, va_z, vb_x, vb_y, vb_z} = '0;
    k_spring = 31'd65536; c_damp = '0; rest_len = 31'd65536;
    n_mismatch = 0; n_accepted = 0; n_queued = 0;
    in_took = 1'b0; in_gap = 0; out_gap = 0; cycles = 0;
    idle_en = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset register values
    queue_directed();
    queue_random(80);
    drain();

    // extreme registers, top data bit must be dropped
    set_regs(32'hffff_ffff, 32'hffff_ffff, 32'h0);
    queue_directed();
    queue_random(80);
    drain();

    // zero stiffness and damping, spare index write must be ignored
    set_regs(32'h0, 32'h0, 32'h7fff_ffff);
    write_reg(CFG_IDX_SPARE, 32'h1234_5678);
    queue_random(60);
    drain();

    // random settings
    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0004_0000),
               $urandom_range(0, 32'h0008_0000));
      if (p == 2) begin
        queue_random(20);
        wait (springs_to_send.size() == 0);
        idle_en = 1'b0;           // final stretch at full rate
        queue_random(60);
      end else begin
        queue_random(70);
      end
      drain();
    end

    if (n_mismatch == 0) $display("tb_damped_spring_force_3d: PASS");
    else                 $display("tb_damped_spring_force_3d: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/dsf_pkg.sv
sv/dsf_sqrt.sv
sv/dsf_div.sv
sv/damped_spring_force_3d.sv
sv/dsf_checker.sv
tb/tb_damped_spring_force_3d.sv
